@@ sv/pfu_pkg.sv @@
// Package with format constants, operation codes and pipeline item types for the float unit.
package pfu_pkg;

	localparam int EXP_WIDTH  = 8;
	localparam int FRAC_WIDTH = 23;

	localparam int PK_W      = 1 + EXP_WIDTH + FRAC_WIDTH;
	localparam int MANT_W    = FRAC_WIDTH + 1;
	localparam int VAL_W     = FRAC_WIDTH + 5;
	localparam int REM_W     = MANT_W + 1;
	localparam int DIV_STEPS = FRAC_WIDTH + 5;
	localparam int LZ_W      = $clog2(VAL_W);
	localparam int EXPS_W    = ((EXP_WIDTH > LZ_W) ? EXP_WIDTH : LZ_W) + 3;
	localparam int EXP_MAX   = (2 ** EXP_WIDTH) - 1;
	localparam int EXP_BIAS  = (2 ** (EXP_WIDTH - 1)) - 1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic                       spec;
		logic [PK_W-1:0]            spec_val;
		logic                       sgn;
		logic signed [EXPS_W-1:0]   ex;
		logic [VAL_W-1:0]           v;
		logic [REM_W-1:0]           r;
		logic [MANT_W-1:0]          dm;
	} item_t;

	function automatic logic [PK_W-1:0] make_inf(input logic s);
		logic [PK_W-1:0] y;
		y = '0;
		y[PK_W-1] = s;
		y[PK_W-2:FRAC_WIDTH] = '1;
		return y;
	endfunction

	function automatic logic [PK_W-1:0] make_qnan();
		logic [PK_W-1:0] y;
		y = '0;
		y[PK_W-2:FRAC_WIDTH] = '1;
		y[FRAC_WIDTH-1] = 1'b1;
		return y;
	endfunction

endpackage

@@ sv/pfu_if.sv @@
// Handshake interfaces for the request and response channels of the float unit.
interface pfu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source(output valid, opcode, operand_a, operand_b, input ready);
	modport sink(input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface pfu_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;

	modport source(output valid, result_bits, input ready);
	modport sink(input valid, result_bits, output ready);
endinterface

@@ sv/param_float_add_sub_mul_div_unit.sv @@
// Pipelined float add, subtract, multiply and divide unit.
// Each operation passes the same stages: decode, set-up, restoring divider, leading-zero
// count, shift, rounding, packing; the divider takes one stage per quotient bit.
// Throughput: one item per cycle; the whole pipeline holds when a response is not taken.
// Reset: arst_n clears every stage valid bit at once; data registers are not reset.
module param_float_add_sub_mul_div_unit
	import pfu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pfu_req_if.sink     req,
	pfu_rsp_if.source   rsp
);

	typedef struct packed {
		op_t                      op;
		logic                     spec;
		logic [PK_W-1:0]          spec_val;
		logic                     sgn;
		logic signed [EXPS_W-1:0] ex;
		logic [MANT_W-1:0]        ma;
		logic [MANT_W-1:0]        mb;
		logic [EXP_WIDTH-1:0]     d;
		logic                     eff_sub;
	} dec_t;

	function automatic logic [PK_W-1:0] to_pk(input logic [31:0] x);
		logic [PK_W-1:0] y;
		y = '0;
		for (int i = 0; i < PK_W; i++) begin
			if (i < 32) y[i] = x[i];
		end
		return y;
	endfunction

	function automatic logic [31:0] to_out(input logic [PK_W-1:0] x);
		logic [31:0] y;
		y = '0;
		for (int i = 0; i < 32; i++) begin
			if (i < PK_W) y[i] = x[i];
		end
		return y;
	endfunction

	localparam logic signed [EXPS_W-1:0] BIAS_S = EXPS_W'(EXP_BIAS);
	localparam logic signed [EXPS_W-1:0] EMAX_S = EXPS_W'(EXP_MAX);

	logic adv;

	// Decode and special cases.
	logic [PK_W-1:0]      pa, pb;
	logic                 sa, sb;
	logic [EXP_WIDTH-1:0] ea, eb;
	logic [FRAC_WIDTH-1:0] fa, fb;
	logic [MANT_W-1:0]    ma, mb;
	logic                 a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
	logic signed [EXPS_W-1:0] eas, ebs;
	dec_t                 dec;

	always_comb begin
		pa = to_pk(req.operand_a);
		pb = to_pk(req.operand_b);
		sa = pa[PK_W-1];
		sb = pb[PK_W-1] ^ (op_t'(req.opcode) == OP_SUB);
		ea = pa[PK_W-2:FRAC_WIDTH];
		eb = pb[PK_W-2:FRAC_WIDTH];
		fa = pa[FRAC_WIDTH-1:0];
		fb = pb[FRAC_WIDTH-1:0];
		ma = {1'b1, fa};
		mb = {1'b1, fb};
		eas = $signed({{(EXPS_W-EXP_WIDTH){1'b0}}, ea});
		ebs = $signed({{(EXPS_W-EXP_WIDTH){1'b0}}, eb});
		a_nan  = (&ea) && (|fa);
		b_nan  = (&eb) && (|fb);
		a_inf  = (&ea) && !(|fa);
		b_inf  = (&eb) && !(|fb);
		a_zero = !(|ea) && !(|fa);
		b_zero = !(|eb) && !(|fb);
		a_big  = (ea > eb) || (ea == eb && ma >= mb);

		dec          = '0;
		dec.op       = op_t'(req.opcode);
		dec.spec     = 1'b1;
		dec.spec_val = '0;
		case (op_t'(req.opcode))
			OP_ADD, OP_SUB: begin
				dec.sgn     = a_big ? sa : sb;
				dec.ex      = a_big ? eas : ebs;
				dec.ma      = a_big ? ma : mb;
				dec.mb      = a_big ? mb : ma;
				dec.d       = a_big ? (ea - eb) : (eb - ea);
				dec.eff_sub = sa ^ sb;
				if (a_nan || b_nan) dec.spec_val = make_qnan();
				else if (a_inf && b_inf) dec.spec_val = (sa == sb) ? make_inf(sa) : make_qnan();
				else if (a_inf) dec.spec_val = make_inf(sa);
				else if (b_inf) dec.spec_val = make_inf(sb);
				else if (a_zero) dec.spec_val = b_zero ? '0 : {sb, eb, fb};
				else if (b_zero) dec.spec_val = {sa, ea, fa};
				else dec.spec = 1'b0;
			end
			OP_MUL: begin
				dec.sgn = sa ^ sb;
				dec.ex  = eas + ebs - BIAS_S;
				dec.ma  = ma;
				dec.mb  = mb;
				if (a_nan || b_nan) dec.spec_val = make_qnan();
				else if (a_inf && b_inf) dec.spec_val = (sa == sb) ? make_qnan() : make_inf(sa);
				else if (a_inf) dec.spec_val = make_inf(sa);
				else if (b_inf) dec.spec_val = make_inf(sb);
				else if (a_zero || b_zero) dec.spec_val = '0;
				else dec.spec = 1'b0;
			end
			default: begin
				dec.sgn = sa ^ sb;
				// The quotient lands one place high; rounding takes the extra bit back.
				dec.ex  = eas - ebs + BIAS_S - EXPS_W'(1);
				dec.ma  = ma;
				dec.mb  = mb;
				if (a_nan || b_nan) dec.spec_val = make_qnan();
				else if (a_inf && b_inf) dec.spec_val = (sa == sb) ? make_qnan() : make_inf(sa);
				else if (a_inf) dec.spec_val = make_inf(sa);
				else if (b_inf) dec.spec_val = '0;
				else if (a_zero) dec.spec_val = '0;
				else if (b_zero) dec.spec_val = make_inf(sa);
				else dec.spec = 1'b0;
			end
		endcase
	end

	logic vld_s1;
	dec_t dec_s1;

	// Alignment and add, product, or divider set-up.
	localparam int AW = FRAC_WIDTH + 4;
	localparam int PW = 2 * MANT_W + 3;
	logic [AW-1:0]         va, vb0, vb, msk;
	logic [AW:0]           sum;
	logic [2*MANT_W-1:0]   prod;
	logic [PW-1:0]         ext;
	item_t                 prep;

	always_comb begin
		va   = {dec_s1.ma, 3'b000};
		vb0  = {dec_s1.mb, 3'b000};
		msk  = ~({AW{1'b1}} << dec_s1.d);
		if (32'(dec_s1.d) >= 32'(AW)) vb = AW'(1);
		else vb = (vb0 >> dec_s1.d) | AW'(|(vb0 & msk));
		sum  = dec_s1.eff_sub ? ({1'b0, va} - {1'b0, vb}) : ({1'b0, va} + {1'b0, vb});
		prod = dec_s1.ma * dec_s1.mb;
		ext  = {prod, 3'b000};

		prep          = '0;
		prep.op       = dec_s1.op;
		prep.spec     = dec_s1.spec;
		prep.spec_val = dec_s1.spec_val;
		prep.sgn      = dec_s1.sgn;
		prep.ex       = dec_s1.ex;
		prep.dm       = dec_s1.mb;
		case (dec_s1.op)
			OP_ADD, OP_SUB: prep.v = sum;
			OP_MUL: prep.v = ext[PW-1:FRAC_WIDTH] | VAL_W'(|ext[FRAC_WIDTH-1:0]);
			default: prep.r = {1'b0, dec_s1.ma};
		endcase
	end

	logic  vld_dv [DIV_STEPS+1];
	item_t itm_dv [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_dv[0] <= 1'b0;
		end else if (adv) begin
			vld_s1    <= req.valid;
			vld_dv[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1    <= dec;
			itm_dv[0] <= prep;
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		pfu_div_stage u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (vld_dv[g]),
			.itm_i  (itm_dv[g]),
			.vld_o  (vld_dv[g+1]),
			.itm_o  (itm_dv[g+1])
		);
	end

	// Leading-zero count.
	item_t           nrm;
	logic [LZ_W-1:0] lz;

	always_comb begin
		nrm = itm_dv[DIV_STEPS];
		if (nrm.op == OP_DIV) nrm.v[0] = nrm.v[0] | (|nrm.r);
		if (!nrm.spec && !(|nrm.v)) begin
			nrm.spec     = 1'b1;
			nrm.spec_val = '0;
		end
		lz = '0;
		if (!nrm.v[VAL_W-1]) begin
			for (int i = 0; i < VAL_W - 1; i++) begin
				if (nrm.v[i]) lz = LZ_W'(VAL_W - 2 - i);
			end
		end
	end

	logic            vld_n1, vld_n2, vld_r1, vld_r2;
	item_t           itm_n1, itm_n2, itm_r1;
	logic [LZ_W-1:0] lz_n1;
	logic [31:0]     res_r2;

	// Normalising shift.
	item_t sft;
	always_comb begin
		sft    = itm_n1;
		sft.v  = itm_n1.v << lz_n1;
		sft.ex = itm_n1.ex - $signed({{(EXPS_W-LZ_W){1'b0}}, lz_n1});
	end

	// Round to nearest, ties to even.
	item_t                rnd;
	logic [VAL_W-1:0]     vr;
	logic [FRAC_WIDTH+1:0] mant;
	logic [2:0]           rem;
	logic                 inc;
	always_comb begin
		rnd = itm_n2;
		vr  = itm_n2.v;
		if (itm_n2.v[VAL_W-1]) begin
			vr     = (itm_n2.v >> 1) | VAL_W'(itm_n2.v[0]);
			rnd.ex = itm_n2.ex + EXPS_W'(1);
		end
		rem  = vr[2:0];
		inc  = (rem > 3'd4) || (rem == 3'd4 && vr[3]);
		mant = vr[VAL_W-2:3] + (FRAC_WIDTH+2)'(inc);
		if (mant[FRAC_WIDTH+1]) begin
			mant   = mant >> 1;
			rnd.ex = rnd.ex + EXPS_W'(1);
		end
		rnd.v = VAL_W'(mant);
	end

	// Range check and packing.
	logic [PK_W-1:0] pk;
	always_comb begin
		if (itm_r1.spec) pk = itm_r1.spec_val;
		else if (itm_r1.ex >= EMAX_S) pk = make_inf(itm_r1.sgn);
		else if (itm_r1.ex < 0) pk = '0;
		else pk = {itm_r1.sgn, itm_r1.ex[EXP_WIDTH-1:0], itm_r1.v[FRAC_WIDTH-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_n1 <= 1'b0;
			vld_n2 <= 1'b0;
			vld_r1 <= 1'b0;
			vld_r2 <= 1'b0;
		end else if (adv) begin
			vld_n1 <= vld_dv[DIV_STEPS];
			vld_n2 <= vld_n1;
			vld_r1 <= vld_n2;
			vld_r2 <= vld_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itm_n1 <= nrm;
			lz_n1  <= lz;
			itm_n2 <= sft;
			itm_r1 <= rnd;
			res_r2 <= to_out(pk);
		end
	end

	// The pipeline moves whenever the output stage is empty or being taken.
	assign adv             = !vld_r2 || rsp.ready;
	assign req.ready       = adv;
	assign rsp.valid       = vld_r2;
	assign rsp.result_bits = res_r2;

endmodule

@@ sv/pfu_div_stage.sv @@
// One restoring division step of the float unit pipeline, with its stage register.
module pfu_div_stage
	import pfu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  vld_i,
	input  item_t itm_i,
	output logic  vld_o,
	output item_t itm_o
);

	logic               vld_s1;
	item_t              itm_s1;
	item_t              nxt;
	logic               ge;
	logic [REM_W-1:0]   diff;
	logic [REM_W-1:0]   rr;

	always_comb begin
		nxt  = itm_i;
		ge   = itm_i.r >= {1'b0, itm_i.dm};
		diff = itm_i.r - {1'b0, itm_i.dm};
		rr   = ge ? diff : itm_i.r;
		if (itm_i.op == OP_DIV && !itm_i.spec) begin
			nxt.r = {rr[REM_W-2:0], 1'b0};
			nxt.v = {itm_i.v[VAL_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			itm_s1 <= nxt;
		end
	end

	assign vld_o = vld_s1;
	assign itm_o = itm_s1;

endmodule

@@ sv/pfu_checker.sv @@
// Port-level checker for the float unit and its bind to the top level.
module pfu_checker
	import pfu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] result_bits
);

	localparam logic [PK_W-1:0] QNAN = make_qnan();

	// A stalled response keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_bits))
		else $error("response changed while stalled");

	// The unit takes a request exactly when its output is free to move.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("request ready does not follow the output stage");

	// A stall at the output also holds the request side.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while the output is stalled");

	// Any NaN result is the single quiet NaN.
	a_qnan_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (&result_bits[PK_W-2:FRAC_WIDTH]) && (|result_bits[FRAC_WIDTH-1:0])
		|-> result_bits[PK_W-1:0] == QNAN)
		else $error("NaN result is not the quiet NaN");

endmodule

bind param_float_add_sub_mul_div_unit pfu_checker u_pfu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.result_bits (rsp.result_bits)
);

@@ sim/param_float_add_sub_mul_div_unit_tb.sv @@
// Self-checking testbench for the pipelined float add, subtract, multiply and divide unit.
`timescale 1ns / 100ps

module param_float_add_sub_mul_div_unit_tb;
	import pfu_pkg::*;

	localparam int N_RANDOM   = 1430;
	localparam int STALL_MAX  = 5000;
	localparam int DRAIN_WAIT = DIV_STEPS + 20;
	localparam int SW         = EXP_WIDTH + FRAC_WIDTH;

	localparam logic [31:0] QNAN  = 32'h7fc0_0000;
	localparam logic [31:0] PINF  = 32'h7f80_0000;
	localparam logic [31:0] NINF  = 32'hff80_0000;
	localparam logic [31:0] ONE   = 32'h3f80_0000;
	localparam logic [31:0] TWO   = 32'h4000_0000;
	localparam logic [31:0] BIGF  = 32'h7f7f_ffff;
	localparam logic [31:0] TINY  = 32'h0000_0001;
	localparam logic [31:0] NZERO = 32'h8000_0000;

	typedef struct {
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
		logic        known;
		logic [31:0] res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	pfu_req_if req();
	pfu_rsp_if rsp();

	param_float_add_sub_mul_div_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	logic [31:0] expected_results[$];
	int          fault_count;
	int          idle_cycles;
	int          rsp_gap;
	bit          calm_phase;
	bit          hold_rsp;
	stim_row_t   directed_rows[$];

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Field helpers for the packed format.
	function automatic logic is_nan_val(input logic [31:0] x);
		return x[SW-1:FRAC_WIDTH] == EXP_MAX[EXP_WIDTH-1:0] && x[FRAC_WIDTH-1:0] != 0;
	endfunction

	function automatic logic is_inf_val(input logic [31:0] x);
		return x[SW-1:FRAC_WIDTH] == EXP_MAX[EXP_WIDTH-1:0] && x[FRAC_WIDTH-1:0] == 0;
	endfunction

	function automatic logic is_zero_val(input logic [31:0] x);
		return x[SW-1:0] == 0;
	endfunction

	function automatic logic [31:0] inf_of(input logic s);
		return {s, PINF[30:0]};
	endfunction

	function automatic logic [63:0] sticky_shift(input logic [63:0] v, input longint d);
		logic [63:0] m;
		if (d == 0)
			return v;
		if (d >= 64)
			return {63'd0, v != 0};
		m = (64'd1 << d) - 64'd1;
		return (v >> d) | {63'd0, (v & m) != 0};
	endfunction

	// Normalises, rounds to nearest even and packs, with overflow and underflow.
	function automatic logic [31:0] round_to_format(input logic s, input longint ex,
			input logic [63:0] v);
		logic [63:0] mant;
		logic [2:0]  rem;
		if ((v >> (FRAC_WIDTH + 4)) != 0) begin
			v = sticky_shift(v, 1);
			ex++;
		end
		mant = v >> 3;
		rem = v[2:0];
		if (rem > 3'd4 || (rem == 3'd4 && mant[0]))
			mant++;
		if ((mant >> (FRAC_WIDTH + 1)) != 0) begin
			mant >>= 1;
			ex++;
		end
		if (ex >= EXP_MAX)
			return inf_of(s);
		if (ex < 0)
			return '0;
		return {s, ex[EXP_WIDTH-1:0], mant[FRAC_WIDTH-1:0]};
	endfunction

	function automatic logic [31:0] float_sum(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] hi, lo;
		logic [63:0] va, vb, v;
		longint      ex;
		if (is_nan_val(a) || is_nan_val(b))
			return QNAN;
		if (is_inf_val(a) && is_inf_val(b))
			return (a[31] == b[31]) ? inf_of(a[31]) : QNAN;
		if (is_inf_val(a))
			return inf_of(a[31]);
		if (is_inf_val(b))
			return inf_of(b[31]);
		if (is_zero_val(a))
			return is_zero_val(b) ? '0 : b;
		if (is_zero_val(b))
			return a;
		// Same exponent compares by significand, which is the same as comparing low bits.
		if (a[30:0] >= b[30:0]) begin
			hi = a;
			lo = b;
		end else begin
			hi = b;
			lo = a;
		end
		vb = sticky_shift(64'({1'b1, lo[FRAC_WIDTH-1:0]}) << 3,
			longint'(hi[30:23]) - longint'(lo[30:23]));
		va = 64'({1'b1, hi[FRAC_WIDTH-1:0]}) << 3;
		ex = longint'(hi[30:23]);
		if (hi[31] == lo[31]) begin
			v = va + vb;
		end else begin
			v = va - vb;
			if (v == 0)
				return '0;
			while ((v >> (FRAC_WIDTH + 3)) == 0) begin
				v <<= 1;
				ex--;
			end
		end
		return round_to_format(hi[31], ex, v);
	endfunction

	function automatic logic [31:0] float_product(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		logic        s;
		if (is_nan_val(a) || is_nan_val(b))
			return QNAN;
		if (is_inf_val(a) && is_inf_val(b))
			return (a[31] == b[31]) ? QNAN : inf_of(a[31]);
		if (is_inf_val(a))
			return inf_of(a[31]);
		if (is_inf_val(b))
			return inf_of(b[31]);
		if (is_zero_val(a) || is_zero_val(b))
			return '0;
		s = a[31] ^ b[31];
		p = 64'({1'b1, a[FRAC_WIDTH-1:0]}) * 64'({1'b1, b[FRAC_WIDTH-1:0]});
		p = (p >> (FRAC_WIDTH - 3)) | {63'd0, (p & ((64'd1 << (FRAC_WIDTH - 3)) - 64'd1)) != 0};
		return round_to_format(s, longint'(a[30:23]) + longint'(b[30:23]) - EXP_BIAS, p);
	endfunction

	function automatic logic [31:0] float_quotient(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] q, r, dm;
		longint      ex;
		if (is_nan_val(a) || is_nan_val(b))
			return QNAN;
		if (is_inf_val(a) && is_inf_val(b))
			return (a[31] == b[31]) ? QNAN : inf_of(a[31]);
		if (is_inf_val(a))
			return inf_of(a[31]);
		if (is_inf_val(b) || is_zero_val(a))
			return '0;
		if (is_zero_val(b))
			return inf_of(a[31]);
		q = '0;
		r = 64'({1'b1, a[FRAC_WIDTH-1:0]});
		dm = 64'({1'b1, b[FRAC_WIDTH-1:0]});
		for (int i = 0; i < DIV_STEPS; i++) begin
			q <<= 1;
			if (r >= dm) begin
				r -= dm;
				q[0] = 1'b1;
			end
			r <<= 1;
		end
		q[0] = q[0] | (r != 0);
		ex = longint'(a[30:23]) - longint'(b[30:23]) + EXP_BIAS;
		if ((q >> (FRAC_WIDTH + 4)) != 0)
			q = sticky_shift(q, 1);
		else
			ex--;
		return round_to_format(a[31] ^ b[31], ex, q);
	endfunction

	function automatic logic [31:0] float_result(input op_t op, input logic [31:0] a,
			input logic [31:0] b);
		case (op)
			OP_ADD: return float_sum(a, b);
			OP_SUB: return float_sum(a, {~b[31], b[30:0]});
			OP_MUL: return float_product(a, b);
			default: return float_quotient(a, b);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
		fault_count++;
	endtask

	task automatic send_item(input op_t op, input logic [31:0] a, input logic [31:0] b,
			input logic known, input logic [31:0] res);
		logic [31:0] want;
		if (!calm_phase && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		want = float_result(op, a, b);
		if (known && want !== res)
			report_mismatch("directed table", want, res);
		req.valid     <= 1'b1;
		req.opcode    <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		do
			@(posedge clk);
		while (!req.ready);
		expected_results = {expected_results, known ? res : want};
	endtask

	// Random operand biased towards nearby exponents and the edges of the range.
	function automatic logic [31:0] pick_operand(input logic [31:0] other);
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(0, 9))
			0: x[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
			1: x[30:0] = $urandom_range(0, 1) ? 31'd0 : x[30:0];
			2: x[30:23] = $urandom_range(0, 1) ? 8'hfe - 8'($urandom_range(0, 3))
				: 8'($urandom_range(0, 3));
			3, 4, 5: x[30:23] = other[30:23] + 8'($urandom_range(0, 6)) - 8'd3;
			6: x[30:0] = {other[30:3], x[2:0]};
			default: ;
		endcase
		return x;
	endfunction

	function automatic stim_row_t row(input op_t op, input logic [31:0] a, input logic [31:0] b,
			input logic known, input logic [31:0] res);
		stim_row_t t;
		t.op = op;
		t.a = a;
		t.b = b;
		t.known = known;
		t.res = res;
		return t;
	endfunction

	// Response side: bursts of stalls, one long hold-off, checking in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_gap   <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected result", rsp.result_bits, 'x);
				else if (rsp.result_bits !== expected_results[0])
					report_mismatch("result_bits", rsp.result_bits, expected_results.pop_front());
				else
					void'(expected_results.pop_front());
			end
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
			end else if (rsp_gap > 0) begin
				rsp.ready <= 1'b0;
				rsp_gap   <= rsp_gap - 1;
			end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				rsp_gap   <= int'($urandom_range(0, 3));
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		hold_rsp = 1'b0;
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_rsp = 1'b1;
		repeat (120) @(posedge clk);
		hold_rsp = 1'b0;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_MAX) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] a, b;
		fault_count = 0;
		calm_phase = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_ADD;
		req.operand_a = '0;
		req.operand_b = '0;

		directed_rows = {directed_rows, row(OP_ADD, ONE, ONE, 1'b1, TWO)};
		directed_rows = {directed_rows, row(OP_SUB, ONE, ONE, 1'b1, 32'h0)};
		directed_rows = {directed_rows, row(OP_MUL, TWO, TWO, 1'b1, 32'h4080_0000)};
		directed_rows = {directed_rows, row(OP_DIV, ONE, TWO, 1'b1, 32'h3f00_0000)};
		directed_rows = {directed_rows, row(OP_ADD, QNAN | 32'h1, ONE, 1'b1, QNAN)};
		directed_rows = {directed_rows, row(OP_DIV, ONE, 32'hffff_ffff, 1'b1, QNAN)};
		directed_rows = {directed_rows, row(OP_ADD, PINF, PINF, 1'b1, PINF)};
		directed_rows = {directed_rows, row(OP_ADD, PINF, NINF, 1'b1, QNAN)};
		directed_rows = {directed_rows, row(OP_SUB, ONE, PINF, 1'b1, NINF)};
		directed_rows = {directed_rows, row(OP_MUL, NINF, NINF, 1'b1, QNAN)};
		directed_rows = {directed_rows, row(OP_MUL, PINF, NINF, 1'b1, PINF)};
		directed_rows = {directed_rows, row(OP_MUL, NZERO, NINF, 1'b1, NINF)};
		directed_rows = {directed_rows, row(OP_MUL, NZERO, ONE, 1'b1, 32'h0)};
		directed_rows = {directed_rows, row(OP_DIV, NINF, ONE, 1'b1, NINF)};
		directed_rows = {directed_rows, row(OP_DIV, ONE, NINF, 1'b1, 32'h0)};
		directed_rows = {directed_rows, row(OP_DIV, NZERO, NZERO, 1'b1, 32'h0)};
		directed_rows = {directed_rows, row(OP_DIV, 32'hbf80_0000, 32'h0, 1'b1, NINF)};
		directed_rows = {directed_rows, row(OP_ADD, NZERO, 32'hc000_0000, 1'b1, 32'hc000_0000)};
		directed_rows = {directed_rows, row(OP_ADD, NZERO, NZERO, 1'b1, 32'h0)};
		directed_rows = {directed_rows, row(OP_MUL, BIGF, TWO, 1'b1, PINF)};
		directed_rows = {directed_rows, row(OP_ADD, BIGF, BIGF, 1'b1, PINF)};
		directed_rows = {directed_rows, row(OP_MUL, TINY, TINY, 1'b1, 32'h0)};
		directed_rows = {directed_rows, row(OP_DIV, TINY, BIGF, 1'b0, 32'h0)};
		directed_rows = {directed_rows, row(OP_SUB, 32'h3f80_0001, ONE, 1'b0, 32'h0)};
		directed_rows = {directed_rows, row(OP_ADD, ONE, 32'h3380_0000, 1'b0, 32'h0)};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].known, directed_rows[i].res);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 700) begin
				// Pause until the pipeline has drained completely.
				req.valid <= 1'b0;
				while (expected_results.size() != 0)
					@(posedge clk);
			end
			if (n == N_RANDOM - 200)
				calm_phase = 1'b1;
			a = $urandom;
			if ($urandom_range(0, 9) == 0)
				a[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
			b = pick_operand(a);
			send_item(op_t'($urandom_range(0, 3)), a, b, 1'b0, 32'h0);
		end
		req.valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ param_float_add_sub_mul_div_unit.f @@
sv/pfu_pkg.sv
sv/pfu_if.sv
sv/pfu_div_stage.sv
sv/param_float_add_sub_mul_div_unit.sv
sv/pfu_checker.sv
sim/param_float_add_sub_mul_div_unit_tb.sv
